[rtl/mpq_pkg.sv]
// Shared constants, codes and control types for the min-priority queue.
`timescale 1ns / 1ps
package mpq_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int PRIO_W = 16;
	localparam int VAL_W  = 32;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_SHIFT,
		S_RESULT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch_in;
		logic exec;
		logic scan_step;
		logic shift;
		logic load_out;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_scan;
		logic scan_done;
	} dp_stat_t;

endpackage

[rtl/min_priority_queue_fifo_ties_top.sv]
// Top level of the bounded min-priority queue with arrival-order tie breaking.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall) carries op, prio_in and value_in.
//   op enqueue appends the pair at the tail; op dequeue removes the entry
//   with the smallest signed priority, the oldest one on a tie.
//   Output channel (out_valid / out_stall) carries one result per transfer
//   in: status (ok, empty, full) and, on a good dequeue, the removed pair.
//   Sequence: an enqueue, a full enqueue or an empty dequeue passes from the
//   input transfer through the execute state to the result state. A dequeue
//   of held entries adds the minimum scan, which reads one stored entry per
//   cycle through the single read mux of the entry store, then the shift
//   state, which compacts the list. Items are handled one at a time; the next
//   transfer in is taken in the cycle after the result is loaded.
//   The result sits in an output register, so a new item is taken while a
//   result still waits. A stalled receiver holds the result; the block then
//   finishes its current item and waits with in_stall high.
//   Reset empties the queue and drops any pending result; no clearing pass.
module min_priority_queue_fifo_ties_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              op,
	input  logic signed [mpq_pkg::PRIO_W-1:0] prio_in,
	input  logic signed [mpq_pkg::VAL_W-1:0]  value_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic signed [mpq_pkg::PRIO_W-1:0] prio_out,
	output logic signed [mpq_pkg::VAL_W-1:0]  value_out
);

	// Command and status groups between controller and datapath.
	mpq_pkg::dp_cmd_t  cmd;
	mpq_pkg::dp_stat_t stat;

	// Sequence each item: capture, execute, scan, compact, hand off result.
	mpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Hold the entries, find the minimum and drive the result payload.
	mpq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.op        (op),
		.prio_in   (prio_in),
		.value_in  (value_in),
		.status    (status),
		.prio_out  (prio_out),
		.value_out (value_out)
	);

endmodule

[rtl/mpq_ctrl.sv]
// Controller state machine that sequences enqueue, scan, compaction and result.
`timescale 1ns / 1ps
module mpq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  mpq_pkg::dp_stat_t stat,
	output mpq_pkg::dp_cmd_t  cmd
);

	mpq_pkg::state_t state_q;
	mpq_pkg::state_t state_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mpq_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		in_stall      = 1'b1;
		case (state_q)
			mpq_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = mpq_pkg::S_EXEC;
				end
			end
			mpq_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.need_scan ? mpq_pkg::S_SCAN : mpq_pkg::S_RESULT;
			end
			mpq_pkg::S_SCAN: begin
				if (stat.scan_done) begin
					state_d = mpq_pkg::S_SHIFT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			mpq_pkg::S_SHIFT: begin
				cmd.shift = 1'b1;
				state_d   = mpq_pkg::S_RESULT;
			end
			mpq_pkg::S_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = mpq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mpq_pkg::S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/mpq_dp.sv]
// Datapath: entry storage, minimum scan, compaction and result registers.
`timescale 1ns / 1ps
module mpq_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mpq_pkg::dp_cmd_t                 cmd,
	output mpq_pkg::dp_stat_t                stat,
	input  logic                             op,
	input  logic signed [mpq_pkg::PRIO_W-1:0] prio_in,
	input  logic signed [mpq_pkg::VAL_W-1:0]  value_in,
	output logic [1:0]                       status,
	output logic signed [mpq_pkg::PRIO_W-1:0] prio_out,
	output logic signed [mpq_pkg::VAL_W-1:0]  value_out
);

	logic signed [mpq_pkg::PRIO_W-1:0] prio_mem_q  [mpq_pkg::DEPTH];
	logic signed [mpq_pkg::VAL_W-1:0]  value_mem_q [mpq_pkg::DEPTH];
	logic [mpq_pkg::CNT_W-1:0]         fill_q;

	logic                              op_q;
	logic signed [mpq_pkg::PRIO_W-1:0] prio_in_q;
	logic signed [mpq_pkg::VAL_W-1:0]  value_in_q;

	logic [mpq_pkg::CNT_W-1:0]         idx_q;
	logic [mpq_pkg::IDX_W-1:0]         best_idx_q;
	logic signed [mpq_pkg::PRIO_W-1:0] best_prio_q;
	logic signed [mpq_pkg::VAL_W-1:0]  best_value_q;

	mpq_pkg::status_t                  res_status_q;
	logic signed [mpq_pkg::PRIO_W-1:0] res_prio_q;
	logic signed [mpq_pkg::VAL_W-1:0]  res_value_q;
	mpq_pkg::status_t                  out_status_q;
	logic signed [mpq_pkg::PRIO_W-1:0] out_prio_q;
	logic signed [mpq_pkg::VAL_W-1:0]  out_value_q;

	logic                              is_full;
	logic                              is_empty;
	logic                              is_enq;
	logic signed [mpq_pkg::PRIO_W-1:0] scan_prio;
	logic signed [mpq_pkg::VAL_W-1:0]  scan_value;

	assign is_full    = (fill_q == mpq_pkg::CNT_W'(mpq_pkg::DEPTH));
	assign is_empty   = (fill_q == '0);
	assign is_enq     = (op_q == mpq_pkg::OP_ENQ);
	assign scan_prio  = prio_mem_q[idx_q[mpq_pkg::IDX_W-1:0]];
	assign scan_value = value_mem_q[idx_q[mpq_pkg::IDX_W-1:0]];

	assign stat.need_scan = !is_enq && !is_empty;
	assign stat.scan_done = (idx_q >= fill_q);

	// Fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.exec && is_enq && !is_full) begin
			fill_q <= fill_q + 1'b1;
		end else if (cmd.shift) begin
			fill_q <= fill_q - 1'b1;
		end
	end

	// Storage: append at the tail, close the gap after a removal.
	always_ff @(posedge clk) begin
		if (cmd.exec && is_enq && !is_full) begin
			prio_mem_q[fill_q[mpq_pkg::IDX_W-1:0]]  <= prio_in_q;
			value_mem_q[fill_q[mpq_pkg::IDX_W-1:0]] <= value_in_q;
		end else if (cmd.shift) begin
			for (int j = 0; j < mpq_pkg::DEPTH - 1; j++) begin
				if (mpq_pkg::IDX_W'(j) >= best_idx_q) begin
					prio_mem_q[j]  <= prio_mem_q[j + 1];
					value_mem_q[j] <= value_mem_q[j + 1];
				end
			end
		end
	end

	// Input hold, scan state and result registers.
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q       <= op;
			prio_in_q  <= prio_in;
			value_in_q <= value_in;
		end
		if (cmd.exec) begin
			res_prio_q   <= '0;
			res_value_q  <= '0;
			idx_q        <= mpq_pkg::CNT_W'(1);
			best_idx_q   <= '0;
			best_prio_q  <= prio_mem_q[0];
			best_value_q <= value_mem_q[0];
			if (is_enq) begin
				res_status_q <= is_full ? mpq_pkg::ST_FULL : mpq_pkg::ST_OK;
			end else begin
				res_status_q <= is_empty ? mpq_pkg::ST_EMPTY : mpq_pkg::ST_OK;
			end
		end
		if (cmd.scan_step) begin
			// Strict less-than keeps the oldest entry on a tie.
			if (scan_prio < best_prio_q) begin
				best_idx_q   <= idx_q[mpq_pkg::IDX_W-1:0];
				best_prio_q  <= scan_prio;
				best_value_q <= scan_value;
			end
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.shift) begin
			res_prio_q  <= best_prio_q;
			res_value_q <= best_value_q;
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_prio_q   <= res_prio_q;
			out_value_q  <= res_value_q;
		end
	end

	assign status    = out_status_q;
	assign prio_out  = out_prio_q;
	assign value_out = out_value_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= mpq_pkg::CNT_W'(mpq_pkg::DEPTH))
		else $error("fill count above depth");

	a_shift_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> !is_empty)
		else $error("compaction on an empty queue");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> (idx_q < fill_q) && (mpq_pkg::CNT_W'(best_idx_q) < idx_q))
		else $error("scan index outside held entries");

	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && is_enq && !is_full) |=> (fill_q == $past(fill_q) + 1'b1))
		else $error("enqueue did not grow the fill count");

endmodule

[tb/tb_min_priority_queue_fifo_ties_top.sv]
// Self-checking testbench for the bounded min-priority queue with FIFO tie breaking.
`timescale 1ns / 1ps

// One expected result of the queue: status and, on a good dequeue, the removed pair.
typedef struct {
	mpq_pkg::status_t   status;
	logic signed [15:0] prio;
	logic signed [31:0] value;
} queue_result_t;

// Shadow of the queue contents plus the results still owed by the block.
class mpq_scoreboard;
	logic signed [15:0] held_prio[$];
	logic signed [31:0] held_value[$];
	queue_result_t      pending[$];
	int                 errors = 0;

	// Apply one accepted transfer to the shadow queue and record its result.
	function void note_input(mpq_pkg::op_t o, logic signed [15:0] p, logic signed [31:0] v);
		queue_result_t r;
		int            best;
		r.status = mpq_pkg::ST_OK;
		r.prio   = '0;
		r.value  = '0;
		if (o == mpq_pkg::OP_ENQ) begin
			if (held_prio.size() >= mpq_pkg::DEPTH) begin
				r.status = mpq_pkg::ST_FULL;
			end else begin
				held_prio.push_back(p);
				held_value.push_back(v);
			end
		end else if (held_prio.size() == 0) begin
			r.status = mpq_pkg::ST_EMPTY;
		end else begin
			// strict less-than keeps the oldest entry on a tie
			best = 0;
			for (int i = 1; i < held_prio.size(); i++)
				if (held_prio[i] < held_prio[best])
					best = i;
			r.prio  = held_prio[best];
			r.value = held_value[best];
			held_prio.delete(best);
			held_value.delete(best);
		end
		pending.push_back(r);
	endfunction

	// Compare one accepted result against the oldest expectation.
	function void check_result(logic [1:0] s, logic signed [15:0] p, logic signed [31:0] v);
		queue_result_t e;
		if (pending.size() == 0) begin
			$error("result transfer with no expectation pending");
			errors++;
			return;
		end
		e = pending.pop_front();
		if (s !== e.status) begin
			$error("status: expected %0d, actual %0d", e.status, s);
			errors++;
		end
		if (p !== e.prio) begin
			$error("prio_out: expected %0d, actual %0d", e.prio, p);
			errors++;
		end
		if (v !== e.value) begin
			$error("value_out: expected %0d, actual %0d", e.value, v);
			errors++;
		end
	endfunction
endclass

module tb_min_priority_queue_fifo_ties_top;

	localparam int NUM_RANDOM  = 700;
	// Hang limit; the slowest run (dequeues of 16 entries, long stalls) stays well under it.
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 40;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic                op        = 1'b0;
	logic signed [15:0]  prio_in   = '0;
	logic signed [31:0]  value_in  = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [1:0]          status;
	logic signed [15:0]  prio_out;
	logic signed [31:0]  value_out;

	int                  cycle_count = 0;
	mpq_scoreboard       sb = new;

	min_priority_queue_fifo_ties_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.prio_in   (prio_in),
		.value_in  (value_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.prio_out  (prio_out),
		.value_out (value_out)
	);

	// 2 ns clock.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Abort on a hang: a missing result or a stuck in_stall ends up here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Check every result transfer. Signals are read in the active region of the
	// edge, so out_stall still holds the value the receiver drove last cycle.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, prio_out, value_out);
	end

	// Present one item and hold it until the block takes it. Leave in_valid
	// high on return so a following item goes out back to back.
	task automatic send_item(mpq_pkg::op_t o, logic signed [15:0] p, logic signed [31:0] v);
		in_valid <= 1'b1;
		op       <= o;
		prio_in  <= p;
		value_in <= v;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_input(o, p, v);
	endtask

	// Drop valid for a gap between bursts.
	task automatic sender_gap(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Receiver: pick a stall pattern at random (none, random, two of three),
	// and twice hold off for a long stretch so the queue backs up into in_stall.
	initial begin
		int rx_cycle;
		int hold_left;
		int mode;
		rx_cycle  = 0;
		hold_left = 0;
		mode      = 0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle % 64 == 0)
				mode = $urandom_range(0, 2);
			if (rx_cycle == 400 || rx_cycle == 4000)
				hold_left = 300;
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 99) < 40);
					default: out_stall <= (rx_cycle % 3 != 0);
				endcase
			end
		end
	end

	// Sender: reset, directed items, then random bursts; finally drain and report.
	initial begin
		logic signed [15:0] dir_prio [16];
		mpq_pkg::op_t       o;
		logic signed [15:0] p;
		logic signed [31:0] v;
		int                 enq_pct;
		int                 burst_left;

		dir_prio = '{
			16'sd5, -16'sd32768, 16'sd32767, 16'sd5, 16'sd0, -16'sd1, -16'sd32768, 16'sd7,
			16'sd32767, 16'sd5, -16'sd1, 16'sd0, 16'sd3, -16'sd32768, 16'sd2, 16'sd1
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Dequeue on an empty queue.
		send_item(mpq_pkg::OP_DEQ, 16'sd0, 32'sd0);
		// Fill to capacity with extreme priorities and ties; distinct values
		// expose the order in which tied entries leave.
		for (int i = 0; i < 16; i++) begin
			v = (i % 2 == 0) ? (32'sh8000_0000 + i) : (32'sh7fff_fff0 + i);
			send_item(mpq_pkg::OP_ENQ, dir_prio[i], v);
		end
		// Enqueue on a full queue: dropped, status full.
		send_item(mpq_pkg::OP_ENQ, -16'sd32768, 32'sh7fff_ffff);
		send_item(mpq_pkg::OP_ENQ, 16'sd32767, 32'sh8000_0000);
		// Pull the most negative priorities, oldest first.
		repeat (6) send_item(mpq_pkg::OP_DEQ, 16'sh7fff, -32'sd1);

		// Random part. Every 50 items pick an enqueue bias so the queue swings
		// between full and empty; priorities come from full range, a narrow
		// range that forces ties, or the extremes.
		enq_pct    = 50;
		burst_left = $urandom_range(1, 24);
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (n % 50 == 0) begin
				case ($urandom_range(0, 2))
					0: enq_pct = 85;
					1: enq_pct = 50;
					default: enq_pct = 15;
				endcase
			end
			o = ($urandom_range(0, 99) < enq_pct) ? mpq_pkg::OP_ENQ : mpq_pkg::OP_DEQ;
			case ($urandom_range(0, 3))
				0: p = 16'($signed($urandom_range(0, 6)) - 3);
				1: begin
					case ($urandom_range(0, 3))
						0: p = 16'sh8000;
						1: p = 16'sh7fff;
						2: p = 16'sd0;
						default: p = -16'sd1;
					endcase
				end
				default: p = 16'($urandom);
			endcase
			v = $urandom;
			send_item(o, p, v);
			burst_left--;
			if (burst_left == 0) begin
				sender_gap($urandom_range(1, 8));
				burst_left = $urandom_range(1, 24);
			end
		end
		in_valid <= 1'b0;

		// Wait out the remaining results, then give stray results a chance to show.
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/mpq_pkg.sv
rtl/mpq_ctrl.sv
rtl/mpq_dp.sv
rtl/min_priority_queue_fifo_ties_top.sv
tb/tb_min_priority_queue_fifo_ties_top.sv
